[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the scanline delta unfilter.
// Needs nothing else; files that check their logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off while reset is high.
`define SDU_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Implication into the next cycle, also checked while reset is high.
`define SDU_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

[rtl/sdu_pkg.sv]
// Types and constants shared by the scanline delta unfilter modules.
// No dependencies.
package sdu_pkg;

   // line control codes
   localparam logic [7:0] CTL_RAW    = 8'd0;
   localparam logic [7:0] CTL_PLAIN  = 8'd1;
   localparam logic [7:0] CTL_HDELTA = 8'd2;
   localparam logic [7:0] CTL_VDELTA = 8'd3;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_COUNT  = 1'b1;
   localparam int CSR_DATA_W = 16;
   localparam int LEN_W      = 14;
   localparam int CNT_W      = 16;

   // front-to-back queue
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      OP_PASS,
      OP_HDELTA,
      OP_VDELTA,
      OP_BAD
   } op_type;

   // one classified item, column travels beside it
   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       col_zero;
      logic       first_line;
      logic       eol;
      logic       eoi;
   } item_type;

endpackage

[rtl/sdu_req_if.sv]
// Input channel of the scanline delta unfilter: control code and data byte.
// No dependencies.
interface sdu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] control;
   logic [7:0] data_byte;

   modport source (output valid, output control, output data_byte, input ready);
   modport sink   (input valid, input control, input data_byte, output ready);
endinterface

[rtl/sdu_rsp_if.sv]
// Result channel of the scanline delta unfilter: pixel byte and flags.
// No dependencies.
interface sdu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       last_of_line;
   logic       last_of_image;
   logic       error;

   modport source (output valid, output pixel_byte, output last_of_line,
                   output last_of_image, output error, input ready);
   modport sink   (input valid, input pixel_byte, input last_of_line,
                   input last_of_image, input error, output ready);
endinterface

[rtl/sdu_front.sv]
// Front end: configuration registers, column/row tracking, code classification.
// Depends on sdu_pkg and sdu_req_if.
module sdu_front
   import sdu_pkg::*;
#(
   parameter int MAX_LINE = 8192,
   parameter int AW       = $clog2(MAX_LINE),
   parameter int LW       = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   sdu_req_if.sink               req_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output item_type              push_item,
   output logic [AW-1:0]         push_col
);

   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic [CNT_W-1:0] line_count_ff, line_count_in;
   logic [AW-1:0]    column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             first_line_ff, first_line_in;

   logic [LW-1:0]    len_ext;
   logic [LW-1:0]    len_eff;
   logic [LW-1:0]    col_next;
   logic [CNT_W:0]   row_next;
   logic [CNT_W:0]   count_eff;
   logic             eol;
   logic             eoi;
   logic             accept;
   op_type           op;

   assign accept         = req_chan.valid & push_ready;
   assign req_chan.ready = push_ready;

   // configuration writes
   always_comb begin
      line_length_in = line_length_ff;
      line_count_in  = line_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_LINE_LENGTH: line_length_in = csr_write_data[LEN_W-1:0];
            REG_LINE_COUNT:  line_count_in  = csr_write_data[CNT_W-1:0];
         endcase
      end
   end

   // effective length and count, with out-of-range values clamped
   always_comb begin
      len_ext = LW'(line_length_ff);
      priority if (len_ext == '0) begin
         len_eff = LW'(1);
      end else if (len_ext > LW'(MAX_LINE)) begin
         len_eff = LW'(MAX_LINE);
      end else begin
         len_eff = len_ext;
      end
      count_eff = (line_count_ff == '0) ? (CNT_W+1)'(1) : {1'b0, line_count_ff};
   end

   assign col_next = LW'(column_ff) + LW'(1);
   assign row_next = {1'b0, row_ff} + (CNT_W+1)'(1);
   assign eol      = (col_next >= len_eff);
   assign eoi      = eol & (row_next >= count_eff);

   always_comb begin
      unique case (req_chan.control)
         CTL_RAW, CTL_PLAIN: op = OP_PASS;
         CTL_HDELTA:         op = OP_HDELTA;
         CTL_VDELTA:         op = OP_VDELTA;
         default:            op = OP_BAD;
      endcase
   end

   assign push_valid           = req_chan.valid;
   assign push_col             = column_ff;
   assign push_item.op         = op;
   assign push_item.data_byte  = req_chan.data_byte;
   assign push_item.col_zero   = (column_ff == '0);
   assign push_item.first_line = first_line_ff;
   assign push_item.eol        = eol;
   assign push_item.eoi        = eoi;

   // position update per accepted item
   always_comb begin
      column_in     = column_ff;
      row_in        = row_ff;
      first_line_in = first_line_ff;
      if (accept) begin
         if (eol) begin
            column_in = '0;
            if (eoi) begin
               row_in        = '0;
               first_line_in = 1'b1;
            end else begin
               row_in        = row_next[CNT_W-1:0];
               first_line_in = 1'b0;
            end
         end else begin
            column_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LEN_W'(1);
         line_count_ff  <= CNT_W'(1);
         column_ff      <= '0;
         row_ff         <= '0;
         first_line_ff  <= 1'b1;
      end else begin
         line_length_ff <= line_length_in;
         line_count_ff  <= line_count_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         first_line_ff  <= first_line_in;
      end
   end

endmodule

[rtl/sdu_queue.sv]
// Short queue between front and back end: classified items and their columns.
// Depends on sdu_pkg.
module sdu_queue
   import sdu_pkg::*;
#(
   parameter int AW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  item_type      push_item,
   input  logic [AW-1:0] push_col,
   output logic          pop_valid,
   input  logic          pop_ready,
   output item_type      pop_item,
   output logic [AW-1:0] pop_col
);

   item_type        item_ff [QDEPTH];
   logic [AW-1:0]   col_ff  [QDEPTH];
   logic [QAW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]    count_ff, count_in;
   logic            push;
   logic            pop;

   assign push_ready = (count_ff != (QAW+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_item   = item_ff[rd_ptr_ff];
   assign pop_col    = col_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
         col_ff[wr_ptr_ff]  <= push_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/sdu_back.sv]
// Back end: line store, byte reconstruction, sticky error and output register.
// Depends on sdu_pkg and sdu_rsp_if.
module sdu_back
   import sdu_pkg::*;
#(
   parameter int MAX_LINE = 8192,
   parameter int AW       = $clog2(MAX_LINE)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  item_type      pop_item,
   input  logic [AW-1:0] pop_col,
   sdu_rsp_if.source     rsp_chan
);

   logic [7:0]    line_store [MAX_LINE];

   // execute stage
   logic          exe_valid_ff, exe_valid_in;
   item_type      exe_item_ff;
   logic [AW-1:0] exe_col_ff;
   logic [7:0]    rd_data_ff;
   logic          fwd_ff;
   logic [7:0]    fwd_data_ff;

   logic [7:0]    prev_out_ff, prev_out_in;
   logic          error_ff, error_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_pixel_ff;
   logic          out_eol_ff;
   logic          out_eoi_ff;
   logic          out_error_ff;

   logic          exe_fire;
   logic          pop;
   logic          fwd_in;
   logic [7:0]    above;
   logic [7:0]    value;

   assign exe_fire  = exe_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign pop_ready = ~exe_valid_ff | exe_fire;
   assign pop       = pop_valid & pop_ready;

   // a write from the execute stage to the column being read is forwarded
   assign fwd_in = exe_fire & (exe_col_ff == pop_col);

   always_comb begin
      above = exe_item_ff.first_line ? 8'd0 : (fwd_ff ? fwd_data_ff : rd_data_ff);
      unique case (exe_item_ff.op)
         OP_PASS:   value = exe_item_ff.data_byte;
         OP_HDELTA: value = exe_item_ff.col_zero ? exe_item_ff.data_byte
                                                 : prev_out_ff - exe_item_ff.data_byte;
         OP_VDELTA: value = above - exe_item_ff.data_byte;
         OP_BAD:    value = 8'd0;
      endcase
   end

   always_comb begin
      exe_valid_in = exe_valid_ff;
      prev_out_in  = prev_out_ff;
      error_in     = error_ff;
      out_valid_in = out_valid_ff;
      if (pop) begin
         exe_valid_in = 1'b1;
      end else if (exe_fire) begin
         exe_valid_in = 1'b0;
      end
      if (exe_fire) begin
         prev_out_in  = value;
         error_in     = error_ff | (exe_item_ff.op == OP_BAD);
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // line store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (exe_fire) begin
         line_store[exe_col_ff] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff <= line_store[pop_col];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         exe_item_ff <= pop_item;
         exe_col_ff  <= pop_col;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= value;
      end
      if (exe_fire) begin
         out_pixel_ff <= error_in ? 8'd0 : value;
         out_eol_ff   <= exe_item_ff.eol;
         out_eoi_ff   <= exe_item_ff.eoi;
         out_error_ff <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         prev_out_ff  <= 8'd0;
         error_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         exe_valid_ff <= exe_valid_in;
         prev_out_ff  <= prev_out_in;
         error_ff     <= error_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_byte    = out_pixel_ff;
   assign rsp_chan.last_of_line  = out_eol_ff;
   assign rsp_chan.last_of_image = out_eoi_ff;
   assign rsp_chan.error         = out_error_ff;

endmodule

[rtl/scanline_delta_unfilter.sv]
// Scanline delta unfilter: rebuilds pixel bytes from inflated line bytes.
// Path from req accept to rsp valid: queue entry, execute stage, output register.
// Throughput: 1 item per cycle while rsp ready does not stall, set by the line
// store's single read and single write port per cycle and the one-item execute stage.
// Reset: synchronous, clears positions, queue, valid flags, error and the
// last output byte; the line store is not cleared and needs no sweep.
module scanline_delta_unfilter
   import sdu_pkg::*;
#(
   parameter int MAX_LINE = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   sdu_req_if.sink               req_chan,
   sdu_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

`include "assert_macros.svh"

   // column address width, and a length width that holds MAX_LINE itself
   localparam int AW = $clog2(MAX_LINE);
   localparam int LW = ($clog2(MAX_LINE + 1) > LEN_W) ? $clog2(MAX_LINE + 1) : LEN_W;

   // front -> queue
   logic          push_valid;
   logic          push_ready;
   item_type      push_item;
   logic [AW-1:0] push_col;

   // queue -> back
   logic          pop_valid;
   logic          pop_ready;
   item_type      pop_item;
   logic [AW-1:0] pop_col;

   // Front: takes one item per cycle whenever the queue has room, tracks
   // column and row against the clamped line_length and line_count, and
   // marks line and image ends.
   sdu_front #(
      .MAX_LINE (MAX_LINE),
      .AW       (AW),
      .LW       (LW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item),
      .push_col         (push_col)
   );

   // Queue: a few entries of slack so the front keeps taking items while
   // the result side stalls for a short while.
   sdu_queue #(
      .AW (AW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .push_col   (push_col),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .pop_col    (pop_col)
   );

   // Back: reads the line store on pop (column known ahead), computes the
   // byte from the registered read with a bypass for a same-column write, then
   // writes the store and loads the output register.
   sdu_back #(
      .MAX_LINE (MAX_LINE),
      .AW       (AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .pop_col   (pop_col),
      .rsp_chan  (rsp_chan)
   );

   // every accepted item lands in the queue the same cycle
   `SDU_ASSERT_HOLDS(a_accept_pushes, clock, reset, req_chan.valid && req_chan.ready, push_valid && push_ready)
   // an image end is always a line end
   `SDU_ASSERT_HOLDS(a_eoi_is_eol, clock, reset, rsp_chan.valid && rsp_chan.last_of_image, rsp_chan.last_of_line)
   // once the error flag shows, the pixel is forced to zero
   `SDU_ASSERT_HOLDS(a_error_zero, clock, reset, rsp_chan.valid && rsp_chan.error, rsp_chan.pixel_byte == 8'd0)
   // no result is shown right after reset
   `SDU_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_chan.valid)

endmodule
